// ===== sv/lbcm_pkg.sv =====
// Package for the LED matrix bit-plane scan controller.
// Holds the shared widths, reset values, opcodes and register indexes.
// No dependencies; every other file of the block imports it.
package lbcm_pkg;

   // Panel geometry defaults and the cap on results per scan tick.
   localparam int PANEL_WIDTH_DEFAULT  = 64;
   localparam int PANEL_HEIGHT_DEFAULT = 32;
   localparam int MAX_RESULTS          = 64;
   localparam int FRAME_DEPTH_DEFAULT  = 2 * PANEL_WIDTH_DEFAULT * PANEL_HEIGHT_DEFAULT;

   // Field widths.
   localparam int PIXEL_W    = 6;
   localparam int COLUMN_W   = 6;
   localparam int ROW_ADDR_W = 4;
   localparam int HOLD_W     = 16;
   localparam int OPCODE_W   = 2;

   // Stream widths.
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 32;

   // Register port.
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;
   localparam int CSR_INDEX_BIT = 2;

   // Hold period reset values.
   localparam logic [HOLD_W-1:0] MSB_HOLD_RESET = 16'd49999;
   localparam logic [HOLD_W-1:0] LSB_HOLD_RESET = 16'd24999;

   // Bit positions of the color pairs inside an RGB222 pixel (LSB of each pair).
   localparam int RED_LSB   = 4;
   localparam int GREEN_LSB = 2;
   localparam int BLUE_LSB  = 0;

   // Request opcodes; the fourth code is accepted and ignored.
   typedef enum logic [OPCODE_W-1:0] {
      OP_TICK  = 2'd0,
      OP_WRITE = 2'd1,
      OP_SWAP  = 2'd2
   } opcode_type;

   // Register indexes as seen on the address bit that selects them.
   typedef enum logic {
      REG_MSB_HOLD = 1'b0,
      REG_LSB_HOLD = 1'b1
   } csr_reg_type;

endpackage

// ===== sv/lbcm_frame_store.sv =====
// Frame store of the LED matrix scan controller: both pixel buffers in one memory.
// One write port and two registered read ports that share a read enable.
// Depends on lbcm_pkg for the pixel width.
module lbcm_frame_store #(
   parameter int DEPTH = lbcm_pkg::FRAME_DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(DEPTH)-1:0]      wr_addr,
   input  logic [lbcm_pkg::PIXEL_W-1:0]  wr_data,
   input  logic                          rd_en,
   input  logic [$clog2(DEPTH)-1:0]      rd_top_addr,
   input  logic [$clog2(DEPTH)-1:0]      rd_bot_addr,
   output logic [lbcm_pkg::PIXEL_W-1:0]  rd_top_data,
   output logic [lbcm_pkg::PIXEL_W-1:0]  rd_bot_data
);
   import lbcm_pkg::*;

   logic [PIXEL_W-1:0] mem [DEPTH];
   logic [PIXEL_W-1:0] rd_top_ff;
   logic [PIXEL_W-1:0] rd_bot_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read ports; the data holds while no read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_top_ff <= mem[rd_top_addr];
         rd_bot_ff <= mem[rd_bot_addr];
      end
   end

   assign rd_top_data = rd_top_ff;
   assign rd_bot_data = rd_bot_ff;

endmodule

// ===== sv/led_matrix_bcm_scan_controller.sv =====
// Scan controller for a scan-multiplexed RGB LED panel with a double-buffered
// RGB222 frame store and two bit planes. A write request stores one pixel in the
// back buffer and a swap request exchanges the buffers. A scan tick reads the
// current row pair of the front buffer and returns one result per column,
// min(PANEL_WIDTH, 64) results at one column per cycle while the result stream
// does not stall; the rate is set by the two read ports of the frame store,
// which fetch the upper and lower pixel of one column per cycle.
// The last result of a tick carries the row address and the hold period of the
// plane (MSB plane first, then LSB plane, then the next row). After reset a
// clearing pass zeroes all 2*PANEL_WIDTH*PANEL_HEIGHT entries of the store
// (4096 by default), one entry per cycle; no request is taken until it ends;
// register writes are taken at any time. The next request is taken as soon as
// the last column of a tick has been read, while its results still drain.
// Depends on lbcm_pkg and lbcm_frame_store.
module led_matrix_bcm_scan_controller #(
   parameter int PANEL_WIDTH  = lbcm_pkg::PANEL_WIDTH_DEFAULT,
   parameter int PANEL_HEIGHT = lbcm_pkg::PANEL_HEIGHT_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // Request stream.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // tdata: pixel_x[5:0], pixel_y[10:6], pixel_value[16:11], zeros above.
   input  logic [lbcm_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // tuser: opcode[1:0].
   input  logic [lbcm_pkg::OPCODE_W-1:0]     req_tuser,
   // Result stream.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // tdata: column[5:0], top_red[6], top_green[7], top_blue[8], bottom_red[9],
   // bottom_green[10], bottom_blue[11], row_address[15:12], hold_period[31:16].
   output logic [lbcm_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   output logic                              rsp_tlast,
   // Register port.
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [lbcm_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [lbcm_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [lbcm_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import lbcm_pkg::*;

   // Geometry.
   localparam int PLANE_SIZE = PANEL_WIDTH * PANEL_HEIGHT;
   localparam int DEPTH      = 2 * PLANE_SIZE;
   localparam int AW         = $clog2(DEPTH);
   localparam int SCAN_ROWS  = PANEL_HEIGHT / 2;
   localparam int ROW_W      = (SCAN_ROWS > 1) ? $clog2(SCAN_ROWS) : 1;
   localparam int COUNT      = (PANEL_WIDTH > MAX_RESULTS) ? MAX_RESULTS : PANEL_WIDTH;
   localparam int CNT_W      = $clog2(COUNT);

   localparam logic [AW-1:0]    PLANE_OFS  = AW'(PLANE_SIZE);
   localparam logic [AW-1:0]    BOT_OFS    = AW'(SCAN_ROWS * PANEL_WIDTH);
   localparam logic [AW-1:0]    ROW_STRIDE = AW'(PANEL_WIDTH);
   localparam logic [AW-1:0]    LAST_ENTRY = AW'(DEPTH - 1);
   localparam logic [CNT_W-1:0] LAST_COL   = CNT_W'(COUNT - 1);
   localparam logic [ROW_W-1:0] LAST_ROW   = ROW_W'(SCAN_ROWS - 1);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN
   } state_type;

   // Control registers.
   state_type        state_ff,    state_in;
   logic [AW-1:0]    clr_ff,      clr_in;
   logic [CNT_W-1:0] col_ff,      col_in;
   logic             front_ff,    front_in;
   logic [ROW_W-1:0] row_ff,      row_in;
   logic             msb_ff,      msb_in;
   logic             s1_valid_ff, s1_valid_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [HOLD_W-1:0] msb_hold_ff, msb_hold_in;
   logic [HOLD_W-1:0] lsb_hold_ff, lsb_hold_in;

   // Scan context captured at the tick.
   logic [AW-1:0]         scan_base_ff, scan_base_in;
   logic                  scan_msb_ff,  scan_msb_in;
   logic [ROW_ADDR_W-1:0] scan_pair_ff, scan_pair_in;
   logic [HOLD_W-1:0]     scan_hold_ff, scan_hold_in;

   // Read stage, aligned with the memory read data.
   logic [COLUMN_W-1:0]   s1_col_ff,  s1_col_in;
   logic                  s1_last_ff, s1_last_in;
   logic                  s1_msb_ff,  s1_msb_in;
   logic [ROW_ADDR_W-1:0] s1_row_ff,  s1_row_in;
   logic [HOLD_W-1:0]     s1_hold_ff, s1_hold_in;

   // Output register. Color vectors are red, green, blue from bit 0 up.
   logic [COLUMN_W-1:0]   rsp_col_ff,  rsp_col_in;
   logic [2:0]            rsp_top_ff,  rsp_top_in;
   logic [2:0]            rsp_bot_ff,  rsp_bot_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic [ROW_ADDR_W-1:0] rsp_row_ff,  rsp_row_in;
   logic [HOLD_W-1:0]     rsp_hold_ff, rsp_hold_in;

   // Request fields.
   opcode_type           req_opcode;
   logic [5:0]           req_pixel_x;
   logic [4:0]           req_pixel_y;
   logic [PIXEL_W-1:0]   req_pixel_value;

   logic                 req_fire;
   logic                 out_free;
   logic                 s1_move;
   logic                 issue;
   logic                 wr_hit;
   logic [AW-1:0]        wr_addr;
   logic                 mem_wr_en;
   logic [AW-1:0]        mem_wr_addr;
   logic [PIXEL_W-1:0]   mem_wr_data;
   logic [AW-1:0]        rd_top_addr;
   logic [AW-1:0]        rd_bot_addr;
   logic [PIXEL_W-1:0]   rd_top_data;
   logic [PIXEL_W-1:0]   rd_bot_data;
   logic [ROW_W+ROW_ADDR_W-1:0] row_ext;
   logic                 csr_write;
   csr_reg_type          csr_reg;

   assign req_opcode      = opcode_type'(req_tuser);
   assign req_pixel_x     = req_tdata[5:0];
   assign req_pixel_y     = req_tdata[10:6];
   assign req_pixel_value = req_tdata[16:11];

   // Handshake terms.
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_move    = s1_valid_ff && out_free;
   assign issue      = (state_ff == ST_SCAN) && (!s1_valid_ff || out_free);

   // Pixel writes go to the back buffer and are dropped outside the panel.
   assign wr_hit  = req_fire && (req_opcode == OP_WRITE)
                    && (int'(req_pixel_x) < PANEL_WIDTH)
                    && (int'(req_pixel_y) < PANEL_HEIGHT);
   assign wr_addr = (front_ff ? '0 : PLANE_OFS) + AW'(req_pixel_y) * ROW_STRIDE
                    + AW'(req_pixel_x);

   // The clearing pass owns the write port until it ends.
   assign mem_wr_en   = (state_ff == ST_CLEAR) || wr_hit;
   assign mem_wr_addr = (state_ff == ST_CLEAR) ? clr_ff : wr_addr;
   assign mem_wr_data = (state_ff == ST_CLEAR) ? '0 : req_pixel_value;

   // Upper and lower pixel of the current column.
   assign rd_top_addr = scan_base_ff + AW'(col_ff);
   assign rd_bot_addr = rd_top_addr + BOT_OFS;

   assign row_ext = {{ROW_ADDR_W{1'b0}}, row_ff};

   lbcm_frame_store #(
      .DEPTH (DEPTH)
   ) u_frame_store (
      .clock       (clock),
      .wr_en       (mem_wr_en),
      .wr_addr     (mem_wr_addr),
      .wr_data     (mem_wr_data),
      .rd_en       (issue),
      .rd_top_addr (rd_top_addr),
      .rd_bot_addr (rd_bot_addr),
      .rd_top_data (rd_top_data),
      .rd_bot_data (rd_bot_data)
   );

   // Register port.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_reg    = csr_reg_type'(csr_paddr[CSR_INDEX_BIT]);

   always_comb begin
      msb_hold_in = msb_hold_ff;
      lsb_hold_in = lsb_hold_ff;
      if (csr_write) begin
         unique case (csr_reg)
            REG_MSB_HOLD: msb_hold_in = csr_pwdata[HOLD_W-1:0];
            REG_LSB_HOLD: lsb_hold_in = csr_pwdata[HOLD_W-1:0];
            default: ;
         endcase
      end
   end

   assign csr_prdata = {{(CSR_DATA_W-HOLD_W){1'b0}},
                        (csr_reg == REG_LSB_HOLD) ? lsb_hold_ff : msb_hold_ff};

   // Sequencer: clearing pass, request decode and column issue.
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      col_in       = col_ff;
      front_in     = front_ff;
      row_in       = row_ff;
      msb_in       = msb_ff;
      scan_base_in = scan_base_ff;
      scan_msb_in  = scan_msb_ff;
      scan_pair_in = scan_pair_ff;
      scan_hold_in = scan_hold_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == LAST_ENTRY) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_opcode)
                  OP_TICK: begin
                     state_in     = ST_SCAN;
                     col_in       = '0;
                     scan_base_in = (front_ff ? PLANE_OFS : '0) + AW'(row_ff) * ROW_STRIDE;
                     scan_msb_in  = msb_ff;
                     scan_pair_in = row_ext[ROW_ADDR_W-1:0];
                     scan_hold_in = msb_ff ? msb_hold_ff : lsb_hold_ff;
                     // MSB plane, then LSB plane, then the next row pair.
                     if (msb_ff) begin
                        msb_in = 1'b0;
                     end else begin
                        msb_in = 1'b1;
                        row_in = (row_ff == LAST_ROW) ? '0 : row_ff + 1'b1;
                     end
                  end
                  OP_SWAP: begin
                     front_in = !front_ff;
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            if (issue) begin
               col_in = col_ff + 1'b1;
               if (col_ff == LAST_COL) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Read stage and output register.
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_col_in    = s1_col_ff;
      s1_last_in   = s1_last_ff;
      s1_msb_in    = s1_msb_ff;
      s1_row_in    = s1_row_ff;
      s1_hold_in   = s1_hold_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_top_in   = rsp_top_ff;
      rsp_bot_in   = rsp_bot_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_hold_in  = rsp_hold_ff;

      if (issue) begin
         s1_valid_in = 1'b1;
         s1_col_in   = COLUMN_W'(col_ff);
         s1_last_in  = (col_ff == LAST_COL);
         s1_msb_in   = scan_msb_ff;
         s1_row_in   = scan_pair_ff;
         s1_hold_in  = scan_hold_ff;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end

      if (s1_move) begin
         rsp_valid_in = 1'b1;
         rsp_col_in   = s1_col_ff;
         // Pick the plane's bit out of each color pair.
         rsp_top_in[0] = s1_msb_ff ? rd_top_data[RED_LSB+1]   : rd_top_data[RED_LSB];
         rsp_top_in[1] = s1_msb_ff ? rd_top_data[GREEN_LSB+1] : rd_top_data[GREEN_LSB];
         rsp_top_in[2] = s1_msb_ff ? rd_top_data[BLUE_LSB+1]  : rd_top_data[BLUE_LSB];
         rsp_bot_in[0] = s1_msb_ff ? rd_bot_data[RED_LSB+1]   : rd_bot_data[RED_LSB];
         rsp_bot_in[1] = s1_msb_ff ? rd_bot_data[GREEN_LSB+1] : rd_bot_data[GREEN_LSB];
         rsp_bot_in[2] = s1_msb_ff ? rd_bot_data[BLUE_LSB+1]  : rd_bot_data[BLUE_LSB];
         rsp_last_in  = s1_last_ff;
         // Row address and hold period ride on the final column only.
         rsp_row_in   = s1_last_ff ? s1_row_ff : '0;
         rsp_hold_in  = s1_last_ff ? s1_hold_ff : '0;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         col_ff       <= '0;
         front_ff     <= 1'b0;
         row_ff       <= '0;
         msb_ff       <= 1'b1;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         msb_hold_ff  <= MSB_HOLD_RESET;
         lsb_hold_ff  <= LSB_HOLD_RESET;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         col_ff       <= col_in;
         front_ff     <= front_in;
         row_ff       <= row_in;
         msb_ff       <= msb_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         msb_hold_ff  <= msb_hold_in;
         lsb_hold_ff  <= lsb_hold_in;
      end
   end

   // Payload.
   always_ff @(posedge clock) begin
      scan_base_ff <= scan_base_in;
      scan_msb_ff  <= scan_msb_in;
      scan_pair_ff <= scan_pair_in;
      scan_hold_ff <= scan_hold_in;
      s1_col_ff    <= s1_col_in;
      s1_last_ff   <= s1_last_in;
      s1_msb_ff    <= s1_msb_in;
      s1_row_ff    <= s1_row_in;
      s1_hold_ff   <= s1_hold_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_top_ff   <= rsp_top_in;
      rsp_bot_ff   <= rsp_bot_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_hold_ff  <= rsp_hold_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {rsp_hold_ff, rsp_row_ff, rsp_bot_ff, rsp_top_ff, rsp_col_ff};

   // A held read stage is not overwritten while the output is stalled.
   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_free |=> s1_valid_ff && $stable(s1_col_ff))
      else $error("read stage changed while the output was stalled");

   // The clearing pass covers the whole store before requests are taken.
   a_clear_complete: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) && (state_in == ST_IDLE) |-> clr_ff == LAST_ENTRY)
      else $error("clearing pass ended early");

   // No pixel write lands while a scan is reading the store.
   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> state_ff != ST_SCAN)
      else $error("frame store written during a scan");

   // The column counter stays within the emitted columns.
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> col_ff <= LAST_COL)
      else $error("column counter out of range");

endmodule

// ===== bench/tb_led_matrix_bcm_scan_controller.sv =====
// Self-checking testbench for the LED matrix bit-plane scan controller.
// Predicts every column result from its own copy of the frame store and registers.
// Depends on lbcm_pkg and led_matrix_bcm_scan_controller.
`timescale 1ns / 1ps

module tb_led_matrix_bcm_scan_controller;
   import lbcm_pkg::*;

   localparam int PANEL_W   = PANEL_WIDTH_DEFAULT;
   localparam int PANEL_H   = PANEL_HEIGHT_DEFAULT;
   localparam int SCAN_ROWS = PANEL_H / 2;
   localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
   localparam int IDLE_PCT          = 21;
   localparam int IDLE_DRAIN_CYCLES = 8;
   localparam int LONG_STALL_CYCLES = 400;

   // One column result as it appears on tlast and tdata, highest bit first.
   typedef struct packed {
      logic        last;
      logic [15:0] hold;
      logic [3:0]  row_addr;
      logic        bot_blue;
      logic        bot_green;
      logic        bot_red;
      logic        top_blue;
      logic        top_green;
      logic        top_red;
      logic [5:0]  column;
   } column_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [OPCODE_W-1:0]    req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_psel = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_paddr = '0;
   logic [CSR_DATA_W-1:0]  csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   // Panel state as the block should hold it.
   logic [PIXEL_W-1:0] panel_image [2][PANEL_H][PANEL_W];
   logic               front_buf = 1'b0;
   int                 row_pair = 0;
   logic               msb_plane = 1'b1;
   logic [HOLD_W-1:0]  msb_hold = MSB_HOLD_RESET;
   logic [HOLD_W-1:0]  lsb_hold = LSB_HOLD_RESET;

   column_result_type column_results_due[$];

   int  mismatch_count = 0;
   int  results_checked = 0;
   int  requests_sent = 0;
   int  ticks_sent = 0;
   int  stall_left = 0;
   bit  calm = 1'b0;

   led_matrix_bcm_scan_controller i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Free-running clock, 2 ns period.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Applies one accepted request to the panel state and queues the columns it emits.
   task automatic apply_to_panel(logic [OPCODE_W-1:0] op, logic [5:0] x, logic [4:0] y,
                                 logic [PIXEL_W-1:0] v);
      int                count;
      int                sh;
      logic [5:0]        top_px;
      logic [5:0]        bot_px;
      column_result_type r;
      case (op)
         OP_WRITE: begin
            if (x < PANEL_W && y < PANEL_H) panel_image[~front_buf][y][x] = v;
         end
         OP_SWAP: begin
            front_buf = ~front_buf;
         end
         OP_TICK: begin
            count = (PANEL_W > MAX_RESULTS) ? MAX_RESULTS : PANEL_W;
            sh = msb_plane ? 1 : 0;
            for (int c = 0; c < count; c++) begin
               top_px = panel_image[front_buf][row_pair][c];
               bot_px = panel_image[front_buf][row_pair + SCAN_ROWS][c];
               r = '0;
               r.column    = 6'(c);
               r.top_red   = top_px[RED_LSB + sh];
               r.top_green = top_px[GREEN_LSB + sh];
               r.top_blue  = top_px[BLUE_LSB + sh];
               r.bot_red   = bot_px[RED_LSB + sh];
               r.bot_green = bot_px[GREEN_LSB + sh];
               r.bot_blue  = bot_px[BLUE_LSB + sh];
               if (c == count - 1) begin
                  r.last     = 1'b1;
                  r.row_addr = 4'(row_pair);
                  r.hold     = msb_plane ? msb_hold : lsb_hold;
               end
               column_results_due.push_back(r);
            end
            // MSB plane first, then LSB plane, then the next row pair.
            if (msb_plane) begin
               msb_plane = 1'b0;
            end else begin
               msb_plane = 1'b1;
               row_pair = (row_pair + 1) % SCAN_ROWS;
            end
         end
         default: ;  // The unused opcode has no effect.
      endcase
   endtask

   // Offers one request at the falling edge and waits until it is taken.
   task automatic send_request(logic [OPCODE_W-1:0] op, logic [5:0] x, logic [4:0] y,
                               logic [PIXEL_W-1:0] v);
      @(negedge clock);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = op;
      req_tdata  = {{(REQ_TDATA_W - 17){1'b0}}, v, y, x};
      do @(posedge clock); while (!req_tready);
      apply_to_panel(op, x, y, v);
      requests_sent++;
      if (op == OP_TICK) ticks_sent++;
   endtask

   // Drops the request valid and waits until every column result has come back.
   task automatic settle();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (column_results_due.size() != 0) @(posedge clock);
      repeat (IDLE_DRAIN_CYCLES) @(posedge clock);
   endtask

   // Writes a hold register over the register port and reads it back.
   task automatic write_hold_register(csr_reg_type idx, logic [HOLD_W-1:0] value);
      logic [CSR_DATA_W-1:0] readback;
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {idx, 2'b00};
      csr_pwdata  = {16'($urandom), value};
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (idx == REG_MSB_HOLD) msb_hold = value;
      else lsb_hold = value;
      @(negedge clock);
      csr_pwrite  = 1'b0;
      csr_penable = 1'b0;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      readback = csr_prdata;
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      if (readback !== {16'h0, value}) begin
         $display("%0t ns: register %s readback mismatch, expected %0d, actual %0d",
                  $time, idx.name(), value, readback);
         mismatch_count++;
      end
   endtask

   // Random request mix with pixel rows biased toward the row pair about to be scanned.
   task automatic send_random_request();
      int                  pick;
      logic [OPCODE_W-1:0] op;
      logic [4:0]          y;
      pick = $urandom_range(99);
      if (pick < 25) op = OP_TICK;
      else if (pick < 75) op = OP_WRITE;
      else if (pick < 90) op = OP_SWAP;
      else op = OP_UNUSED;
      if ($urandom_range(1)) y = {1'($urandom), 4'(row_pair)};
      else y = 5'($urandom_range(31));
      send_request(op, 6'($urandom_range(63)), y, 6'($urandom_range(63)));
   endtask

   // Scans of the cleared store with the reset hold periods, both planes of row 0.
   task automatic test_cleared_store();
      send_request(OP_TICK, 6'd63, 5'd31, 6'd63);
      send_request(OP_TICK, 6'd0, 5'd0, 6'd0);
   endtask

   // Pixel extremes on row pair 1, a swap, and writes that must stay in the back buffer.
   task automatic test_pixel_extremes();
      send_request(OP_WRITE, 6'd0, 5'd1, 6'd63);
      send_request(OP_WRITE, 6'd63, 5'd1, 6'h2A);
      send_request(OP_WRITE, 6'd0, 5'd17, 6'h15);
      send_request(OP_WRITE, 6'd63, 5'd17, 6'd63);
      send_request(OP_WRITE, 6'd31, 5'd17, 6'd0);
      send_request(OP_SWAP, 6'd63, 5'd31, 6'd63);
      send_request(OP_UNUSED, 6'd63, 5'd31, 6'd63);
      send_request(OP_TICK, 6'd0, 5'd0, 6'd0);
      // The buffer that was front before the swap is now written.
      send_request(OP_WRITE, 6'd0, 5'd1, 6'd0);
      send_request(OP_TICK, 6'd0, 5'd0, 6'd0);
   endtask

   // Hold periods at both ends of their range on both planes.
   task automatic test_hold_extremes();
      settle();
      write_hold_register(REG_MSB_HOLD, 16'd0);
      write_hold_register(REG_LSB_HOLD, 16'hFFFF);
      send_request(OP_TICK, 6'd0, 5'd0, 6'd0);
      send_request(OP_TICK, 6'd0, 5'd0, 6'd0);
      settle();
      write_hold_register(REG_MSB_HOLD, 16'hFFFF);
      write_hold_register(REG_LSB_HOLD, 16'd0);
      send_request(OP_TICK, 6'd0, 5'd0, 6'd0);
      send_request(OP_TICK, 6'd0, 5'd0, 6'd0);
   endtask

   // Result side held off for a long stretch while ticks keep being offered.
   task automatic test_result_back_pressure();
      settle();
      calm = 1'b1;
      stall_left = LONG_STALL_CYCLES;
      repeat (6) begin
         send_request(OP_WRITE, 6'($urandom_range(63)), {1'($urandom), 4'(row_pair)},
                      6'($urandom_range(63)));
         send_request(OP_TICK, 6'd0, 5'd0, 6'd0);
      end
      calm = 1'b0;
   endtask

   // Sender goes quiet until the block has drained, then resumes.
   task automatic test_sender_pause();
      repeat (8) send_random_request();
      settle();
      repeat (8) send_random_request();
   endtask

   // Random traffic in phases with new hold periods between phases.
   task automatic test_random_traffic();
      for (int phase = 0; phase < 4; phase++) begin
         settle();
         write_hold_register(REG_MSB_HOLD, 16'($urandom_range(65535)));
         write_hold_register(REG_LSB_HOLD, 16'($urandom_range(65535)));
         calm = (phase == 1);
         repeat (105) send_random_request();
      end
      calm = 1'b0;
   endtask

   // Result side: random stalls, or a counted hold-off when one is requested.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready = 1'b0;
         stall_left--;
      end else begin
         rsp_tready = calm ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
      end
   end

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // Compares each taken result with the oldest predicted column.
   always @(posedge clock) begin
      column_result_type got;
      column_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tlast, rsp_tdata};
         results_checked++;
         if (column_results_due.size() == 0) begin
            $display("%0t ns: unexpected result, expected none, actual column %0d",
                     $time, got.column);
            mismatch_count++;
         end else begin
            want = column_results_due.pop_front();
            check_field("column", want.column, got.column);
            check_field("top_red", want.top_red, got.top_red);
            check_field("top_green", want.top_green, got.top_green);
            check_field("top_blue", want.top_blue, got.top_blue);
            check_field("bottom_red", want.bot_red, got.bot_red);
            check_field("bottom_green", want.bot_green, got.bot_green);
            check_field("bottom_blue", want.bot_blue, got.bot_blue);
            check_field("last", want.last, got.last);
            check_field("row_address", want.row_addr, got.row_addr);
            check_field("hold_period", want.hold, got.hold);
         end
      end
   end

   // Overall limit on the run.
   initial begin
      #1_000_000;
      $display("Timed out with %0d column results outstanding.", column_results_due.size());
      $display("status: fail");
      $finish;
   end

   // Test sequence.
   initial begin
      for (int b = 0; b < 2; b++)
         for (int r = 0; r < PANEL_H; r++)
            for (int c = 0; c < PANEL_W; c++)
               panel_image[b][r][c] = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_cleared_store();
      test_pixel_extremes();
      test_hold_extremes();
      test_result_back_pressure();
      test_sender_pause();
      test_random_traffic();
      settle();
      repeat (20) @(posedge clock);

      $display("Sent %0d requests including %0d scan ticks; checked %0d column results.",
               requests_sent, ticks_sent, results_checked);
      $display("Covered hold period extremes, buffer swaps, long result stalls and pauses.");
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
